// File: sv/sh24_pkg.sv
// Shared types, constants and round function for the SipHash-2-4 block.
package sh24_pkg;

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned VBYTES_W    = 4;
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned BYTES_WORD  = 8;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned FIN_ROUNDS  = 4;
  localparam int unsigned FIN_CNT_W   = $clog2(FIN_ROUNDS);

  localparam logic [WORD_W-1:0] INIT_A    = 64'h736f6d6570736575;
  localparam logic [WORD_W-1:0] INIT_B    = 64'h646f72616e646f6d;
  localparam logic [WORD_W-1:0] INIT_C    = 64'h6c7967656e657261;
  localparam logic [WORD_W-1:0] INIT_D    = 64'h7465646279746573;
  localparam logic [WORD_W-1:0] FINAL_XOR = 64'h00000000000000ff;

  localparam logic [VBYTES_W-1:0] FULL_COUNT = VBYTES_W'(BYTES_WORD);
  localparam int unsigned LEN_SHIFT = WORD_W - LEN_W;

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] d;
  } lanes_t;

  // One queued request: message block, prebuilt tail block and flags.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] tail;
    logic              first;
    logic              last;
    logic              full;   // last word carries eight bytes: compress word too
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MSG2,
    BK_TAIL1,
    BK_TAIL2,
    BK_FIN
  } back_state_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                             input int unsigned r);
    rotl = (x << r) | (x >> (WORD_W - r));
  endfunction

  function automatic lanes_t init_lanes(input logic [WORD_W-1:0] seed);
    lanes_t v;
    v.a = INIT_A ^ seed;
    v.b = INIT_B ^ ~seed;
    v.c = INIT_C ^ seed;
    v.d = INIT_D ^ ~seed;
    init_lanes = v;
  endfunction

  function automatic lanes_t sip_round(input lanes_t vi);
    lanes_t v;
    v = vi;
    v.a = v.a + v.b; v.b = rotl(v.b, 13); v.b = v.b ^ v.a; v.a = rotl(v.a, 32);
    v.c = v.c + v.d; v.d = rotl(v.d, 16); v.d = v.d ^ v.c;
    v.a = v.a + v.d; v.d = rotl(v.d, 21); v.d = v.d ^ v.a;
    v.c = v.c + v.b; v.b = rotl(v.b, 17); v.b = v.b ^ v.c; v.c = rotl(v.c, 32);
    sip_round = v;
  endfunction

endpackage

// File: sv/sh24_front.sv
// Front end: takes message words, tracks length, builds tail blocks.
module sh24_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [sh24_pkg::WORD_W-1:0]         in_message_word,
  input  logic [sh24_pkg::VBYTES_W-1:0]       in_valid_bytes,
  input  logic                                in_last_word,
  input  sh24_pkg::q_status_t                 q_stat,
  output logic                                push,
  output sh24_pkg::job_t                      job
);

  logic [sh24_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic                          open_r, open_nxt;
  logic [sh24_pkg::VBYTES_W-1:0] count;
  logic [sh24_pkg::LEN_W-1:0]    len_sum;
  logic [sh24_pkg::WORD_W-1:0]   masked;

  assign in_stall = q_stat.full;
  assign push     = in_valid & ~q_stat.full;

  always_comb begin
    if (!in_last_word || in_valid_bytes > sh24_pkg::FULL_COUNT) begin
      count = sh24_pkg::FULL_COUNT;
    end else begin
      count = in_valid_bytes;
    end
    len_sum = (open_r ? len_r : '0) + sh24_pkg::LEN_W'(count);

    // keep bytes below the valid count; a full word goes in as its own block
    for (int i = 0; i < sh24_pkg::BYTES_WORD; i++) begin
      masked[i*8 +: 8] = (sh24_pkg::VBYTES_W'(i) < count && count != sh24_pkg::FULL_COUNT)
                         ? in_message_word[i*8 +: 8] : 8'h00;
    end

    job.word  = in_message_word;
    job.tail  = masked | ({{(sh24_pkg::WORD_W-sh24_pkg::LEN_W){1'b0}}, len_sum}
                          << sh24_pkg::LEN_SHIFT);
    job.first = ~open_r;
    job.last  = in_last_word;
    job.full  = in_last_word & (count == sh24_pkg::FULL_COUNT);

    len_nxt  = len_r;
    open_nxt = open_r;
    if (push) begin
      len_nxt  = in_last_word ? '0 : len_sum;
      open_nxt = ~in_last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      open_r <= 1'b0;
    end else begin
      len_r  <= len_nxt;
      open_r <= open_nxt;
    end
  end

endmodule

// File: sv/sh24_queue.sv
// Small FIFO of requests between front and back.
module sh24_queue #(
  parameter int unsigned DEPTH = sh24_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sh24_pkg::job_t      wr_job,
  input  logic                pop,
  output sh24_pkg::job_t      rd_job,
  output sh24_pkg::q_status_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sh24_pkg::job_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & ~stat.empty;
  assign rd_job     = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

endmodule

// File: sv/sh24_back.sv
// Back end: one SipRound per cycle over the four lanes unless a stalled digest holds it, digest register.
module sh24_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sh24_pkg::WORD_W-1:0] seed,
  input  sh24_pkg::job_t              job_in,
  input  sh24_pkg::q_status_t         q_stat,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sh24_pkg::WORD_W-1:0] out_digest
);

  sh24_pkg::back_state_t          state_r, state_nxt;
  sh24_pkg::lanes_t               lanes_r, lanes_nxt;
  sh24_pkg::job_t                 job_r, job_nxt;
  logic [sh24_pkg::FIN_CNT_W-1:0] fin_cnt_r, fin_cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [sh24_pkg::WORD_W-1:0]    digest_r, digest_nxt;
  sh24_pkg::lanes_t               pre, rin, rnd;
  logic                           do_word;

  assign out_valid  = out_valid_r;
  assign out_digest = digest_r;
  assign do_word    = ~job_in.last | job_in.full;

  always_comb begin
    pre   = job_in.first ? sh24_pkg::init_lanes(seed) : lanes_r;
    pre.d = pre.d ^ (do_word ? job_in.word : job_in.tail);
    rin   = (state_r == sh24_pkg::BK_IDLE) ? pre : lanes_r;
    rnd   = sh24_pkg::sip_round(rin);

    state_nxt     = state_r;
    lanes_nxt     = lanes_r;
    job_nxt       = job_r;
    fin_cnt_nxt   = fin_cnt_r;
    out_valid_nxt = out_valid_r & out_stall;
    digest_nxt    = digest_r;
    pop           = 1'b0;

    unique case (state_r)
      sh24_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          job_nxt   = job_in;
          lanes_nxt = rnd;
          state_nxt = do_word ? sh24_pkg::BK_MSG2 : sh24_pkg::BK_TAIL2;
        end
      end
      sh24_pkg::BK_MSG2: begin
        lanes_nxt   = rnd;
        lanes_nxt.a = rnd.a ^ job_r.word;
        if (job_r.last) begin
          // full last word: the length-only tail block follows
          lanes_nxt.d = rnd.d ^ job_r.tail;
          state_nxt   = sh24_pkg::BK_TAIL1;
        end else begin
          state_nxt = sh24_pkg::BK_IDLE;
        end
      end
      sh24_pkg::BK_TAIL1: begin
        lanes_nxt = rnd;
        state_nxt = sh24_pkg::BK_TAIL2;
      end
      sh24_pkg::BK_TAIL2: begin
        lanes_nxt   = rnd;
        lanes_nxt.a = rnd.a ^ job_r.tail;
        lanes_nxt.c = rnd.c ^ sh24_pkg::FINAL_XOR;
        fin_cnt_nxt = '0;
        state_nxt   = sh24_pkg::BK_FIN;
      end
      sh24_pkg::BK_FIN: begin
        if (fin_cnt_r != sh24_pkg::FIN_CNT_W'(sh24_pkg::FIN_ROUNDS - 1)) begin
          lanes_nxt   = rnd;
          fin_cnt_nxt = fin_cnt_r + 1'b1;
        end else if (!out_valid_r || !out_stall) begin
          digest_nxt    = rnd.a ^ rnd.b ^ rnd.c ^ rnd.d;
          out_valid_nxt = 1'b1;
          state_nxt     = sh24_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = sh24_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sh24_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lanes_r   <= lanes_nxt;
    job_r     <= job_nxt;
    fin_cnt_r <= fin_cnt_nxt;
    digest_r  <= digest_nxt;
  end

endmodule

// File: sv/siphash24_keyed_hash.sv
// Top level of the SipHash-2-4 keyed hash block.
//
//  channel | ports                                             | handshake
//  --------+---------------------------------------------------+-------------------
//  input   | in_message_word, in_valid_bytes, in_last_word     | in_valid / in_stall
//  result  | out_digest                                        | out_valid / out_stall
//  config  | cfg_hash_seed (key k0, k1 = ~k0)                  | cfg_valid / cfg_ready
//
// The front writes an accepted request into a QUEUE_DEPTH-entry queue, where
// it is registered before the round unit takes it; in_stall is high only while
// that queue is full. The round unit runs one SipRound per cycle: a non-last
// word in BK_IDLE and BK_MSG2; a last word in BK_IDLE, then in BK_MSG2 and
// BK_TAIL1 if it carries eight bytes, then in BK_TAIL2 and the finalization
// rounds in BK_FIN, the last of which loads the digest register. A stalled
// digest holds the round unit in its final round until out_stall drops. Reset
// (rst_n low, synchronous) empties the queue, closes any open message and clears the seed to zero.
module siphash24_keyed_hash #(
  parameter int unsigned QUEUE_DEPTH = sh24_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sh24_pkg::WORD_W-1:0]   in_message_word,
  input  logic [sh24_pkg::VBYTES_W-1:0] in_valid_bytes,
  input  logic                          in_last_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sh24_pkg::WORD_W-1:0]   out_digest,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sh24_pkg::WORD_W-1:0]   cfg_hash_seed
);

  logic [sh24_pkg::WORD_W-1:0] seed_r;
  sh24_pkg::job_t              wr_job, rd_job;
  sh24_pkg::q_status_t         q_stat;
  logic                        push, pop;

  // Seed register; always ready. Lanes pick it up at the start of a message.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      seed_r <= cfg_hash_seed;
    end
  end

  sh24_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_message_word (in_message_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_last_word    (in_last_word),
    .q_stat          (q_stat),
    .push            (push),
    .job             (wr_job)
  );

  sh24_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  sh24_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .seed       (seed_r),
    .job_in     (rd_job),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_digest (out_digest)
  );

endmodule

// File: tb/tb_siphash24_keyed_hash.sv
// Self-checking testbench for siphash24_keyed_hash: directed and random messages against a predictor.
module tb_siphash24_keyed_hash;

  // Quiet cycles after the last digest before touching the seed or ending:
  // room for a full queue of the slowest requests (eight-byte last word) plus margin.
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam int unsigned RAND_PHASES   = 6;
  localparam int unsigned PHASE_ITEMS   = 200;

  typedef struct packed {
    logic [sh24_pkg::WORD_W-1:0]   word;
    logic [sh24_pkg::VBYTES_W-1:0] nbytes;
    logic                          is_last;
  } word_req_t;

  // Predictor lanes, v0..v3 in the usual SipHash naming.
  typedef struct packed {
    logic [sh24_pkg::WORD_W-1:0] v0;
    logic [sh24_pkg::WORD_W-1:0] v1;
    logic [sh24_pkg::WORD_W-1:0] v2;
    logic [sh24_pkg::WORD_W-1:0] v3;
  } sip_state_t;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [sh24_pkg::WORD_W-1:0]   in_message_word = '0;
  logic [sh24_pkg::VBYTES_W-1:0] in_valid_bytes = '0;
  logic                          in_last_word = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [sh24_pkg::WORD_W-1:0]   out_digest;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [sh24_pkg::WORD_W-1:0]   cfg_hash_seed = '0;

  siphash24_keyed_hash uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_message_word (in_message_word),
    .in_valid_bytes  (in_valid_bytes),
    .in_last_word    (in_last_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest      (out_digest),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_hash_seed   (cfg_hash_seed)
  );

  // Requests waiting to be driven, and digests the predictor owes the monitor.
  word_req_t                   req_q[$];
  logic [sh24_pkg::WORD_W-1:0] digest_q[$];

  // Idle percentages, changed only while req_q is empty.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count = 0;

  // Predictor state: seed as last written, lanes, byte count mod 256, open flag.
  logic [sh24_pkg::WORD_W-1:0] seed_k0 = '0;
  sip_state_t                  lanes;
  logic [sh24_pkg::LEN_W-1:0]  byte_len = '0;
  logic                        msg_open = 1'b0;

  word_req_t                   nxt_req;
  logic [sh24_pkg::WORD_W-1:0] want_digest;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [sh24_pkg::WORD_W-1:0] rol64(
      input logic [sh24_pkg::WORD_W-1:0] x, input int unsigned r);
    return (x << r) | (x >> (sh24_pkg::WORD_W - r));
  endfunction

  function automatic sip_state_t mix_round(input sip_state_t s);
    sip_state_t t;
    t = s;
    t.v0 = t.v0 + t.v1; t.v1 = rol64(t.v1, 13); t.v1 ^= t.v0; t.v0 = rol64(t.v0, 32);
    t.v2 = t.v2 + t.v3; t.v3 = rol64(t.v3, 16); t.v3 ^= t.v2;
    t.v0 = t.v0 + t.v3; t.v3 = rol64(t.v3, 21); t.v3 ^= t.v0;
    t.v2 = t.v2 + t.v1; t.v1 = rol64(t.v1, 17); t.v1 ^= t.v2; t.v2 = rol64(t.v2, 32);
    return t;
  endfunction

  // Standard SipHash block absorb: m into v3, two rounds, m into v0.
  function automatic sip_state_t absorb_block(input sip_state_t s,
                                              input logic [sh24_pkg::WORD_W-1:0] m);
    sip_state_t t;
    t = s;
    t.v3 ^= m;
    t = mix_round(mix_round(t));
    t.v0 ^= m;
    return t;
  endfunction

  // Advances the predictor by one accepted request; a last word yields a digest.
  task automatic hash_word(input logic [sh24_pkg::WORD_W-1:0] w,
                           input logic [sh24_pkg::VBYTES_W-1:0] vb,
                           input logic is_last);
    int unsigned                 n;
    logic [sh24_pkg::WORD_W-1:0] tail;
    if (!msg_open) begin
      // key is (seed, ~seed), latched at the first word of each message
      lanes.v0 = sh24_pkg::INIT_A ^ seed_k0;
      lanes.v1 = sh24_pkg::INIT_B ^ ~seed_k0;
      lanes.v2 = sh24_pkg::INIT_C ^ seed_k0;
      lanes.v3 = sh24_pkg::INIT_D ^ ~seed_k0;
      byte_len = '0;
      msg_open = 1'b1;
    end
    // count only matters on the last word, and saturates at eight
    n = (!is_last || vb > sh24_pkg::BYTES_WORD) ? sh24_pkg::BYTES_WORD : vb;
    byte_len = byte_len + sh24_pkg::LEN_W'(n);
    if (!is_last) begin
      lanes = absorb_block(lanes, w);
    end else begin
      if (n == sh24_pkg::BYTES_WORD) begin
        lanes = absorb_block(lanes, w);
        tail = '0;
      end else if (n == 0) begin
        tail = '0;
      end else begin
        tail = w & ((64'd1 << (8 * n)) - 64'd1);
      end
      tail[sh24_pkg::WORD_W-1 -: sh24_pkg::LEN_W] = byte_len;
      lanes = absorb_block(lanes, tail);
      lanes.v2 ^= sh24_pkg::FINAL_XOR;
      for (int i = 0; i < sh24_pkg::FIN_ROUNDS; i++) lanes = mix_round(lanes);
      digest_q.push_back(lanes.v0 ^ lanes.v1 ^ lanes.v2 ^ lanes.v3);
      msg_open = 1'b0;
      byte_len = '0;
    end
  endtask

  // ------------------------------------------------------------------- driver

  // Input side: a request counts at the edge where in_valid is high and
  // in_stall low; the payload is sampled there before any update. A stalled
  // request stays put; otherwise the next one goes out unless a sender gap is
  // rolled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        hash_word(in_message_word, in_valid_bytes, in_last_word);
      if (!in_valid || !in_stall) begin
        if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt_req = req_q.pop_front();
          in_message_word <= nxt_req.word;
          in_valid_bytes  <= nxt_req.nbytes;
          in_last_word    <= nxt_req.is_last;
          in_valid        <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ------------------------------------------------------------------ monitor

  // Result side: a digest counts when out_valid is high and out_stall low.
  // out_stall is rerolled every cycle from the phase's stall percentage.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          $error("out_digest: no digest expected, actual %h", out_digest);
          err_count++;
        end else begin
          want_digest = digest_q.pop_front();
          if (out_digest !== want_digest) begin
            $error("out_digest: expected %h, actual %h", want_digest, out_digest);
            err_count++;
          end
        end
      end
      out_stall <= $urandom_range(99) < recv_stall_pct;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_req(input logic [sh24_pkg::WORD_W-1:0] w,
                          input logic [sh24_pkg::VBYTES_W-1:0] vb,
                          input logic is_last);
    word_req_t r;
    r.word    = w;
    r.nbytes  = vb;
    r.is_last = is_last;
    req_q.push_back(r);
  endtask

  // nwords body words with random (ignored) counts, then a last word whose
  // count is mostly legal and now and then above eight.
  task automatic queue_message(input int unsigned nwords);
    logic [sh24_pkg::VBYTES_W-1:0] vb;
    for (int i = 0; i < nwords; i++)
      push_req({$urandom, $urandom}, sh24_pkg::VBYTES_W'($urandom_range(15)), 1'b0);
    vb = ($urandom_range(99) < 75)
         ? sh24_pkg::VBYTES_W'($urandom_range(sh24_pkg::BYTES_WORD))
         : sh24_pkg::VBYTES_W'($urandom_range(15));
    push_req({$urandom, $urandom}, vb, 1'b1);
  endtask

  // Block is quiet: nothing left to drive, no digest owed, plus settle time
  // for a trailing body word that produces no result.
  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid || digest_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned                 queued;
    int unsigned                 pick;
    logic [sh24_pkg::WORD_W-1:0] new_seed;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, reset seed (zero), no idling.
    push_req({$urandom, $urandom}, 4'd0, 1'b1);        // empty message, word masked off
    push_req('1, 4'd8, 1'b1);                          // eight-byte last word
    for (int k = 1; k < sh24_pkg::BYTES_WORD; k++)
      push_req('1, sh24_pkg::VBYTES_W'(k), 1'b1);      // partial tails, upper bytes masked
    push_req('0, 4'd15, 1'b1);                         // count above eight saturates
    push_req({$urandom, $urandom}, 4'd9, 1'b1);
    push_req('1, 4'd0, 1'b0);                          // body word: count ignored
    push_req({$urandom, $urandom}, 4'd3, 1'b1);
    push_req('0, 4'd15, 1'b0);
    push_req({$urandom, $urandom}, 4'd5, 1'b0);
    push_req({$urandom, $urandom}, 4'd8, 1'b1);
    push_req({$urandom, $urandom}, 4'd0, 1'b0);        // leave a message open across the seed write

    // Random phases; each starts with a seed write while quiet. Odd phases end
    // with an open message so the new seed must wait for the next message.
    for (int p = 1; p <= RAND_PHASES; p++) begin
      wait_drained();
      case (p)
        1:       new_seed = '1;
        3:       new_seed = 64'h8000_0000_0000_0001;
        4:       new_seed = '0;
        default: new_seed = {$urandom, $urandom};
      endcase
      @(posedge clk);
      cfg_valid     <= 1'b1;
      cfg_hash_seed <= new_seed;
      do @(posedge clk); while (!cfg_ready);
      cfg_valid <= 1'b0;
      seed_k0 = new_seed;

      @(negedge clk);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase

      queued = 0;
      while (queued < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 5) begin
          // long message: byte count wraps past 255
          queue_message(33 + $urandom_range(7));
        end else if (pick < 88) begin
          queue_message($urandom_range(5));
        end else begin
          // noise: any field combination
          push_req({$urandom, $urandom}, sh24_pkg::VBYTES_W'($urandom_range(15)),
                   1'($urandom_range(1)));
        end
        queued = PHASE_ITEMS - (PHASE_ITEMS - req_q.size());
      end
      if (p % 2 == 1 && p != RAND_PHASES)
        push_req({$urandom, $urandom}, sh24_pkg::VBYTES_W'($urandom_range(15)), 1'b0);
      else if (p == RAND_PHASES)
        push_req({$urandom, $urandom},
                 sh24_pkg::VBYTES_W'($urandom_range(sh24_pkg::BYTES_WORD)), 1'b1);
    end

    wait_drained();
    if (digest_q.size() != 0) begin
      $error("out_digest: %0d digests never arrived", digest_q.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: siphash24_keyed_hash.f
sv/sh24_pkg.sv
sv/sh24_front.sv
sv/sh24_queue.sv
sv/sh24_back.sv
sv/siphash24_keyed_hash.sv
tb/tb_siphash24_keyed_hash.sv
